// File: rtl/kms_pkg.sv
// shared types, constants and the key table for the keypad matrix scanner
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

  localparam int TIMER_WIDTH = 24;
  localparam int SETTLE_W    = 16;
  localparam int DEBOUNCE_W  = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CMP_W       = (TIMER_WIDTH > DEBOUNCE_W) ? TIMER_WIDTH : DEBOUNCE_W;

  localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = SETTLE_W'(10);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50000);

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    PH_SETTLE   = 3'b001,
    PH_RELEASE  = 3'b010,
    PH_DEBOUNCE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [3:0] key_index;
    logic [6:0] key_char;
  } result_t;

  function automatic logic [6:0] key_char_of(input logic [3:0] idx);
    logic [6:0] chr;
    case (idx)
      4'd0:    chr = 7'h37;  // 7
      4'd1:    chr = 7'h38;  // 8
      4'd2:    chr = 7'h39;  // 9
      4'd3:    chr = 7'h2F;  // /
      4'd4:    chr = 7'h34;  // 4
      4'd5:    chr = 7'h35;  // 5
      4'd6:    chr = 7'h36;  // 6
      4'd7:    chr = 7'h2A;  // *
      4'd8:    chr = 7'h31;  // 1
      4'd9:    chr = 7'h32;  // 2
      4'd10:   chr = 7'h33;  // 3
      4'd11:   chr = 7'h2D;  // -
      4'd12:   chr = 7'h43;  // C
      4'd13:   chr = 7'h30;  // 0
      4'd14:   chr = 7'h3D;  // =
      default: chr = 7'h2B;  // +
    endcase
    return chr;
  endfunction

  function automatic logic [3:0] row_pattern(input logic [1:0] row);
    return ~(4'b0001 << row);
  endfunction

endpackage

`default_nettype wire

// File: rtl/kms_ctrl.sv
// scan state machine, wait timer and configuration registers
`timescale 1ns / 1ps
`default_nettype none

module kms_ctrl
  import kms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [3:0]           column_levels,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output result_t                   res
);

  localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

  logic [SETTLE_W-1:0]    settle_ticks;
  logic [DEBOUNCE_W-1:0]  debounce_ticks;
  phase_t                 phase, phase_next;
  logic [1:0]             row_index, row_index_next;
  logic [1:0]             release_column, release_column_next;
  logic [TIMER_WIDTH-1:0] wait_timer, wait_timer_next;
  logic [3:0]             held_key, held_key_next;

  logic [CMP_W-1:0] timer_ext, limit_ext;
  logic             timer_done;
  logic             hit;
  logic [1:0]       hit_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks   <= SETTLE_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETTLE:   settle_ticks   <= cfg_data[SETTLE_W-1:0];
        REG_DEBOUNCE: debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // highest-numbered low column wins
  always_comb begin
    hit     = 1'b1;
    hit_col = 2'd0;
    casez (~column_levels)
      4'b1???: hit_col = 2'd3;
      4'b01??: hit_col = 2'd2;
      4'b001?: hit_col = 2'd1;
      4'b0001: hit_col = 2'd0;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    timer_ext = CMP_W'(wait_timer);
    limit_ext = (phase == PH_DEBOUNCE) ? CMP_W'(debounce_ticks) : CMP_W'(settle_ticks);
    timer_done = (timer_ext >= limit_ext) || (wait_timer == TMR_MAX);
  end

  always_comb begin
    phase_next          = phase;
    row_index_next      = row_index;
    release_column_next = release_column;
    wait_timer_next     = wait_timer;
    held_key_next       = held_key;
    res.row_drive       = row_pattern(row_index);
    res.key_valid       = 1'b0;
    res.key_index       = 4'd0;
    res.key_char        = 7'd0;
    unique case (phase)
      PH_SETTLE: begin
        if (timer_done) begin
          wait_timer_next = '0;
          if (hit) begin
            held_key_next       = {row_index, hit_col};
            release_column_next = 2'd0;
            phase_next          = PH_RELEASE;
          end else begin
            row_index_next = row_index + 2'd1;
          end
        end else begin
          wait_timer_next = wait_timer + TIMER_WIDTH'(1);
        end
      end
      PH_RELEASE: begin
        if (column_levels[release_column]) begin
          if (release_column == 2'd3) begin
            release_column_next = 2'd0;
            wait_timer_next     = '0;
            phase_next          = PH_DEBOUNCE;
          end else begin
            release_column_next = release_column + 2'd1;
          end
        end
      end
      PH_DEBOUNCE: begin
        if (timer_done) begin
          res.key_valid   = 1'b1;
          res.key_index   = held_key;
          res.key_char    = key_char_of(held_key);
          phase_next      = PH_SETTLE;
          row_index_next  = 2'd0;
          wait_timer_next = '0;
        end else begin
          wait_timer_next = wait_timer + TIMER_WIDTH'(1);
        end
      end
      default: begin
        phase_next          = PH_SETTLE;
        row_index_next      = 2'd0;
        release_column_next = 2'd0;
        wait_timer_next     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SETTLE;
      row_index      <= 2'd0;
      release_column <= 2'd0;
      wait_timer     <= '0;
      held_key       <= 4'd0;
    end else if (step) begin
      phase          <= phase_next;
      row_index      <= row_index_next;
      release_column <= release_column_next;
      wait_timer     <= wait_timer_next;
      held_key       <= held_key_next;
    end
  end

  a_report_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && res.key_valid) |=> (phase == PH_SETTLE && row_index == 2'd0))
    else $error("report did not restart scan at row 0");

  a_row_held: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RELEASE || phase == PH_DEBOUNCE) |-> (row_index == held_key[3:2]))
    else $error("row moved while a key is held");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    !res.key_valid |-> (res.key_index == 4'd0 && res.key_char == 7'd0))
    else $error("key fields nonzero without a report");

  a_report_only_debounce: assert property (@(posedge clk) disable iff (rst)
    res.key_valid |-> (phase == PH_DEBOUNCE))
    else $error("report outside debounce");

endmodule

`default_nettype wire

// File: rtl/kms_out_reg.sv
// result register between the scan logic and the output channel
`timescale 1ns / 1ps
`default_nettype none

module kms_out_reg
  import kms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         out_valid,
  output logic         busy,
  output result_t      out_res
);

  assign busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("result beat overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/keypad_matrix_scanner_core.sv
// top level of the 4x4 keypad matrix scanner
// the result beat of an accepted input beat is registered and appears in the next cycle
// throughput: one beat per cycle; input stalls only while a result beat is stalled
// each input beat is one scan tick; every beat yields exactly one result beat
// reset (rst, synchronous): settle phase at row 0, timer cleared, no result pending,
// settle_ticks = 10, debounce_ticks = 50000
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_scanner_core
  import kms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [3:0]            column_levels,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 row_drive,
  output logic                       key_valid,
  output logic [3:0]                 key_index,
  output logic [6:0]                 key_char,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic    step;
  logic    busy;
  result_t res;
  result_t out_res;

  assign in_stall = busy;
  assign step     = in_valid & ~busy;

  kms_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .column_levels (column_levels),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .res           (res)
  );

  kms_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .out_res   (out_res)
  );

  assign row_drive = out_res.row_drive;
  assign key_valid = out_res.key_valid;
  assign key_index = out_res.key_index;
  assign key_char  = out_res.key_char;

endmodule

`default_nettype wire
